// File: sv/mvs_pkg.sv
package mvs_pkg;

    localparam int OWED_WIDTH_DEF = 40;

    // Parse phase of the back end.
    localparam logic [1:0] PH_TAG     = 2'd0;
    localparam logic [1:0] PH_HEADER  = 2'd1;
    localparam logic [1:0] PH_PAYLOAD = 2'd2;

    // What a length header counts.
    localparam logic [1:0] KIND_BYTES = 2'd0;
    localparam logic [1:0] KIND_EXT   = 2'd1;
    localparam logic [1:0] KIND_ARRAY = 2'd2;
    localparam logic [1:0] KIND_MAP   = 2'd3;

    // Result status codes.
    localparam logic [2:0] ST_BUSY     = 3'd0;
    localparam logic [2:0] ST_DONE     = 3'd1;
    localparam logic [2:0] ST_BADTAG   = 3'd2;
    localparam logic [2:0] ST_TRUNC    = 3'd3;
    localparam logic [2:0] ST_OVERFLOW = 3'd4;

    // Tag classes produced by the front end.
    localparam logic [2:0] CLS_FIN  = 3'd0;
    localparam logic [2:0] CLS_PAY  = 3'd1;
    localparam logic [2:0] CLS_CONT = 3'd2;
    localparam logic [2:0] CLS_HDR  = 3'd3;
    localparam logic [2:0] CLS_BAD  = 3'd4;

    typedef struct packed {
        logic [2:0] cls;
        logic [4:0] count;
        logic [2:0] hdr_bytes;
        logic [1:0] kind;
    } mvs_tag_t;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
        mvs_tag_t   tag;
    } mvs_item_t;

endpackage

// File: sv/mvs_front.sv
module mvs_front (
    input  logic              in_valid,
    output logic              in_stall,
    input  logic [7:0]        data_byte,
    input  logic              buffer_end,
    input  logic              q_full,
    output logic              push,
    output mvs_pkg::mvs_item_t item
);
    import mvs_pkg::*;

    mvs_tag_t tag;

    // Every byte is decoded as if it were a tag; the back end ignores the
    // result when the byte falls in a header or payload.
    always_comb
    begin
        tag.cls       = CLS_FIN;
        tag.count     = 5'd0;
        tag.hdr_bytes = 3'd0;
        tag.kind      = KIND_BYTES;
        if (data_byte <= 8'h7f || data_byte >= 8'he0 || data_byte == 8'hc0
            || data_byte == 8'hc2 || data_byte == 8'hc3)
        begin
            tag.cls = CLS_FIN;
        end
        else if ((data_byte & 8'he0) == 8'ha0)
        begin
            tag.cls   = CLS_PAY;
            tag.count = data_byte[4:0];
        end
        else if ((data_byte & 8'hf0) == 8'h90)
        begin
            tag.cls   = CLS_CONT;
            tag.count = {1'b0, data_byte[3:0]};
        end
        else if ((data_byte & 8'hf0) == 8'h80)
        begin
            tag.cls   = CLS_CONT;
            tag.count = {data_byte[3:0], 1'b0};
        end
        else
        begin
            unique case (data_byte) inside
                8'hc4, 8'hd9:
                begin
                    tag.cls = CLS_HDR; tag.hdr_bytes = 3'd1; tag.kind = KIND_BYTES;
                end
                8'hc5, 8'hda:
                begin
                    tag.cls = CLS_HDR; tag.hdr_bytes = 3'd2; tag.kind = KIND_BYTES;
                end
                8'hc6, 8'hdb:
                begin
                    tag.cls = CLS_HDR; tag.hdr_bytes = 3'd4; tag.kind = KIND_BYTES;
                end
                8'hc7:
                begin
                    tag.cls = CLS_HDR; tag.hdr_bytes = 3'd1; tag.kind = KIND_EXT;
                end
                8'hc8:
                begin
                    tag.cls = CLS_HDR; tag.hdr_bytes = 3'd2; tag.kind = KIND_EXT;
                end
                8'hc9:
                begin
                    tag.cls = CLS_HDR; tag.hdr_bytes = 3'd4; tag.kind = KIND_EXT;
                end
                8'hdc:
                begin
                    tag.cls = CLS_HDR; tag.hdr_bytes = 3'd2; tag.kind = KIND_ARRAY;
                end
                8'hdd:
                begin
                    tag.cls = CLS_HDR; tag.hdr_bytes = 3'd4; tag.kind = KIND_ARRAY;
                end
                8'hde:
                begin
                    tag.cls = CLS_HDR; tag.hdr_bytes = 3'd2; tag.kind = KIND_MAP;
                end
                8'hdf:
                begin
                    tag.cls = CLS_HDR; tag.hdr_bytes = 3'd4; tag.kind = KIND_MAP;
                end
                8'hcc, 8'hd0:
                begin
                    tag.cls = CLS_PAY; tag.count = 5'd1;
                end
                8'hcd, 8'hd1, 8'hd4:
                begin
                    tag.cls = CLS_PAY; tag.count = 5'd2;
                end
                8'hd5:
                begin
                    tag.cls = CLS_PAY; tag.count = 5'd3;
                end
                8'hca, 8'hce, 8'hd2:
                begin
                    tag.cls = CLS_PAY; tag.count = 5'd4;
                end
                8'hd6:
                begin
                    tag.cls = CLS_PAY; tag.count = 5'd5;
                end
                8'hcb, 8'hcf, 8'hd3:
                begin
                    tag.cls = CLS_PAY; tag.count = 5'd8;
                end
                8'hd7:
                begin
                    tag.cls = CLS_PAY; tag.count = 5'd9;
                end
                8'hd8:
                begin
                    tag.cls = CLS_PAY; tag.count = 5'd17;
                end
                default:
                begin
                    tag.cls = CLS_BAD;
                end
            endcase
        end
    end

    assign in_stall  = q_full;
    assign push      = in_valid && !q_full;
    assign item.data = data_byte;
    assign item.last = buffer_end;
    assign item.tag  = tag;

endmodule

// File: sv/mvs_queue.sv
module mvs_queue (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  mvs_pkg::mvs_item_t wr_item,
    output logic               full,
    input  logic               pop,
    output mvs_pkg::mvs_item_t rd_item,
    output logic               not_empty
);
    import mvs_pkg::*;

    mvs_item_t  slot_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;
    logic [1:0] count_next;

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= wr_item;
        end
    end

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            count_reg <= count_next;
        end
    end

    assign full      = (count_reg == 2'd2);
    assign not_empty = (count_reg != 2'd0);
    assign rd_item   = slot_reg[rd_ptr_reg];

endmodule

// File: sv/mvs_back.sv
module mvs_back #(
    parameter int OWED_WIDTH = mvs_pkg::OWED_WIDTH_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  mvs_pkg::mvs_item_t item,
    input  logic               not_empty,
    output logic               pop,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [2:0]         status,
    output logic [31:0]        value_length
);
    import mvs_pkg::*;

    // owed_base_reg holds the count of values still owed minus one; the
    // owed count is never zero at the start of a transaction.
    logic [1:0]            phase_reg,        phase_next;
    logic [2:0]            header_left_reg,  header_left_next;
    logic [1:0]            length_kind_reg,  length_kind_next;
    logic [31:0]           length_accum_reg, length_accum_next;
    logic [32:0]           payload_left_reg, payload_left_next;
    logic [OWED_WIDTH-1:0] owed_base_reg,    owed_base_next;
    logic [31:0]           byte_count_reg,   byte_count_next;
    logic                  out_valid_reg;
    logic [2:0]            status_reg,       status_next;
    logic [31:0]           value_length_reg;

    logic [31:0]         accum_shift;
    logic [2:0]          hl_dec;
    logic [32:0]         pl_dec;
    logic                act_fin_raw;
    logic                act_pay;
    logic                act_cont;
    logic                act_bad;
    logic                act_hdr;
    logic [32:0]         pay_n;
    logic [32:0]         children;
    logic [OWED_WIDTH:0] cont_sum;
    logic                act_fin;
    logic                owed_zero;
    logic                ovf;

    assign pop = not_empty && (!out_valid_reg || !out_stall);

    assign accum_shift = {length_accum_reg[23:0], item.data};
    assign hl_dec = (header_left_reg != 3'd0) ? header_left_reg - 3'd1 : 3'd0;
    assign pl_dec = (payload_left_reg != 33'd0) ? payload_left_reg - 33'd1 : 33'd0;

    // Work out what this byte does, given the phase.
    always_comb
    begin
        act_fin_raw = 1'b0;
        act_pay     = 1'b0;
        act_cont    = 1'b0;
        act_bad     = 1'b0;
        act_hdr     = 1'b0;
        pay_n       = 33'd0;
        children    = 33'd0;
        unique case (phase_reg)
            PH_HEADER:
            begin
                if (hl_dec == 3'd0)
                begin
                    unique case (length_kind_reg)
                        KIND_BYTES:
                        begin
                            act_pay = 1'b1;
                            pay_n   = {1'b0, accum_shift};
                        end
                        KIND_EXT:
                        begin
                            act_pay = 1'b1;
                            pay_n   = {1'b0, accum_shift} + 33'd1;
                        end
                        KIND_ARRAY:
                        begin
                            act_cont = 1'b1;
                            children = {1'b0, accum_shift};
                        end
                        default:
                        begin
                            act_cont = 1'b1;
                            children = {accum_shift, 1'b0};
                        end
                    endcase
                end
            end
            PH_PAYLOAD:
            begin
                act_fin_raw = (pl_dec == 33'd0);
            end
            default:
            begin
                unique case (item.tag.cls)
                    CLS_FIN:
                    begin
                        act_fin_raw = 1'b1;
                    end
                    CLS_PAY:
                    begin
                        act_pay = 1'b1;
                        pay_n   = {28'd0, item.tag.count};
                    end
                    CLS_CONT:
                    begin
                        act_cont = 1'b1;
                        children = {28'd0, item.tag.count};
                    end
                    CLS_HDR:
                    begin
                        act_hdr = 1'b1;
                    end
                    default:
                    begin
                        act_bad = 1'b1;
                    end
                endcase
            end
        endcase
    end

    // Retire the container and add its children in one add.
    assign cont_sum = {1'b0, owed_base_reg} + (OWED_WIDTH + 1)'(children - 33'd1);

    always_comb
    begin
        phase_next        = phase_reg;
        header_left_next  = header_left_reg;
        length_kind_next  = length_kind_reg;
        length_accum_next = length_accum_reg;
        payload_left_next = payload_left_reg;
        owed_base_next    = owed_base_reg;
        byte_count_next   = (byte_count_reg == '1) ? byte_count_reg : byte_count_reg + 32'd1;
        owed_zero         = 1'b0;
        ovf               = 1'b0;
        act_fin           = act_fin_raw
                            || (act_pay && pay_n == 33'd0)
                            || (act_cont && children == 33'd0);

        if (phase_reg == PH_HEADER)
        begin
            length_accum_next = accum_shift;
            header_left_next  = hl_dec;
        end
        else if (phase_reg == PH_PAYLOAD)
        begin
            payload_left_next = pl_dec;
        end

        if (act_hdr)
        begin
            phase_next        = PH_HEADER;
            header_left_next  = item.tag.hdr_bytes;
            length_kind_next  = item.tag.kind;
            length_accum_next = 32'd0;
        end

        if (act_fin)
        begin
            phase_next     = PH_TAG;
            owed_zero      = (owed_base_reg == '0);
            owed_base_next = owed_base_reg - OWED_WIDTH'(1);
        end
        else if (act_pay)
        begin
            phase_next        = PH_PAYLOAD;
            payload_left_next = pay_n;
        end
        else if (act_cont)
        begin
            phase_next     = PH_TAG;
            owed_base_next = cont_sum[OWED_WIDTH-1:0];
            ovf            = cont_sum[OWED_WIDTH] || (&cont_sum[OWED_WIDTH-1:0]);
        end

        if (act_bad)
        begin
            status_next = ST_BADTAG;
        end
        else if (ovf)
        begin
            status_next = ST_OVERFLOW;
        end
        else if (owed_zero)
        begin
            status_next = ST_DONE;
        end
        else if (item.last)
        begin
            status_next = ST_TRUNC;
        end
        else
        begin
            status_next = ST_BUSY;
        end

        // Any final status starts a fresh value on the next byte.
        if (status_next != ST_BUSY)
        begin
            phase_next        = PH_TAG;
            header_left_next  = 3'd0;
            length_kind_next  = KIND_BYTES;
            length_accum_next = 32'd0;
            payload_left_next = 33'd0;
            owed_base_next    = '0;
            byte_count_next   = 32'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg        <= PH_TAG;
            header_left_reg  <= 3'd0;
            length_kind_reg  <= KIND_BYTES;
            length_accum_reg <= 32'd0;
            payload_left_reg <= 33'd0;
            owed_base_reg    <= '0;
            byte_count_reg   <= 32'd0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            if (pop)
            begin
                phase_reg        <= phase_next;
                header_left_reg  <= header_left_next;
                length_kind_reg  <= length_kind_next;
                length_accum_reg <= length_accum_next;
                payload_left_reg <= payload_left_next;
                owed_base_reg    <= owed_base_next;
                byte_count_reg   <= byte_count_next;
                out_valid_reg    <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            status_reg       <= status_next;
            value_length_reg <= (byte_count_reg == '1) ? byte_count_reg
                                                       : byte_count_reg + 32'd1;
        end
    end

    assign out_valid    = out_valid_reg;
    assign status       = status_reg;
    assign value_length = value_length_reg;

    a_restart: assert property (@(posedge clk) disable iff (!rst_n)
        pop && status_next != ST_BUSY |=>
            phase_reg == PH_TAG && owed_base_reg == '0 && byte_count_reg == 32'd0)
        else $error("state not cleared after a final status");

    a_phase: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg != 2'd3)
        else $error("unused parse phase entered");

    a_header: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_HEADER |-> header_left_reg != 3'd0)
        else $error("header phase with no header bytes left");

    a_payload: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_PAYLOAD |-> payload_left_reg != 33'd0)
        else $error("payload phase with no payload bytes left");

endmodule

// File: sv/msgpack_value_skipper_top.sv
// A byte accepted at a clock edge is written into the queue at that edge; the
// parse stage pops it and registers its result once the output register is free.
// Throughput: one byte per cycle while out_stall is low; the owed-count adder
// and the length counters in the parse stage are combinational.
// Reset (asynchronous, active low) empties the queue and the output register
// and leaves the parser expecting a tag with one value owed.
module msgpack_value_skipper_top #(
    parameter int OWED_WIDTH = mvs_pkg::OWED_WIDTH_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  data_byte,
    input  logic        buffer_end,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [2:0]  status,
    output logic [31:0] value_length
);
    import mvs_pkg::*;

    mvs_item_t wr_item;
    mvs_item_t rd_item;
    logic      push;
    logic      pop;
    logic      q_full;
    logic      q_not_empty;

    mvs_front u_front (
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .data_byte  (data_byte),
        .buffer_end (buffer_end),
        .q_full     (q_full),
        .push       (push),
        .item       (wr_item)
    );

    mvs_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .wr_item   (wr_item),
        .full      (q_full),
        .pop       (pop),
        .rd_item   (rd_item),
        .not_empty (q_not_empty)
    );

    mvs_back #(
        .OWED_WIDTH (OWED_WIDTH)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .item         (rd_item),
        .not_empty    (q_not_empty),
        .pop          (pop),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .status       (status),
        .value_length (value_length)
    );

endmodule

// File: tb/msgpack_value_skipper_top_tb.sv
`timescale 1ns / 1ps

module msgpack_value_skipper_top_tb;

    import mvs_pkg::*;

    localparam int OWED_WIDTH = OWED_WIDTH_DEF;
    localparam logic [63:0] OWED_MAX = (64'd1 << OWED_WIDTH) - 64'd1;

    // MessagePack format bytes.
    localparam logic [7:0] POSFIX_MAX   = 8'h7f;
    localparam logic [7:0] FIXMAP       = 8'h80;
    localparam logic [7:0] FIXARRAY     = 8'h90;
    localparam logic [7:0] FIXSTR       = 8'ha0;
    localparam logic [7:0] TAG_NIL      = 8'hc0;
    localparam logic [7:0] TAG_NEVER    = 8'hc1;
    localparam logic [7:0] TAG_FALSE    = 8'hc2;
    localparam logic [7:0] TAG_TRUE     = 8'hc3;
    localparam logic [7:0] TAG_BIN8     = 8'hc4;
    localparam logic [7:0] TAG_BIN16    = 8'hc5;
    localparam logic [7:0] TAG_BIN32    = 8'hc6;
    localparam logic [7:0] TAG_EXT8     = 8'hc7;
    localparam logic [7:0] TAG_EXT16    = 8'hc8;
    localparam logic [7:0] TAG_EXT32    = 8'hc9;
    localparam logic [7:0] TAG_FLOAT32  = 8'hca;
    localparam logic [7:0] TAG_FLOAT64  = 8'hcb;
    localparam logic [7:0] TAG_UINT8    = 8'hcc;
    localparam logic [7:0] TAG_UINT16   = 8'hcd;
    localparam logic [7:0] TAG_UINT32   = 8'hce;
    localparam logic [7:0] TAG_UINT64   = 8'hcf;
    localparam logic [7:0] TAG_INT8     = 8'hd0;
    localparam logic [7:0] TAG_INT16    = 8'hd1;
    localparam logic [7:0] TAG_INT32    = 8'hd2;
    localparam logic [7:0] TAG_INT64    = 8'hd3;
    localparam logic [7:0] TAG_FIXEXT1  = 8'hd4;
    localparam logic [7:0] TAG_FIXEXT2  = 8'hd5;
    localparam logic [7:0] TAG_FIXEXT4  = 8'hd6;
    localparam logic [7:0] TAG_FIXEXT8  = 8'hd7;
    localparam logic [7:0] TAG_FIXEXT16 = 8'hd8;
    localparam logic [7:0] TAG_STR8     = 8'hd9;
    localparam logic [7:0] TAG_STR16    = 8'hda;
    localparam logic [7:0] TAG_STR32    = 8'hdb;
    localparam logic [7:0] TAG_ARRAY16  = 8'hdc;
    localparam logic [7:0] TAG_ARRAY32  = 8'hdd;
    localparam logic [7:0] TAG_MAP16    = 8'hde;
    localparam logic [7:0] TAG_MAP32    = 8'hdf;
    localparam logic [7:0] NEGFIX       = 8'he0;

    typedef struct packed {
        logic [2:0]  status;
        logic [31:0] length;
    } skip_result_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [7:0]  data_byte = 8'h00;
    logic        buffer_end = 1'b0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [2:0]  status;
    logic [31:0] value_length;

    // Predicted parser state.
    logic [1:0]            ph;
    logic [2:0]            hdr_left;
    logic [1:0]            hdr_kind;
    logic [31:0]           hdr_acc;
    logic [32:0]           skip_left;
    logic [OWED_WIDTH-1:0] owed;
    logic [31:0]           seen;

    skip_result_t status_queue[$];
    int unsigned  mismatches = 0;
    int unsigned  bytes_sent = 0;
    bit           idle_en = 1'b1;
    logic         hold_req = 1'b0;
    int unsigned  stall_left = 0;

    msgpack_value_skipper_top #(.OWED_WIDTH(OWED_WIDTH)) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .data_byte    (data_byte),
        .buffer_end   (buffer_end),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .status       (status),
        .value_length (value_length)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    function automatic void reset_parser();
        ph = PH_TAG;
        hdr_left = '0;
        hdr_kind = '0;
        hdr_acc = '0;
        skip_left = '0;
        owed = OWED_WIDTH'(1);
        seen = '0;
    endfunction

    function automatic void retire_one();
        if (owed != 0)
            owed = owed - OWED_WIDTH'(1);
        ph = PH_TAG;
    endfunction

    function automatic void begin_payload(input logic [32:0] n);
        if (n == 0)
            retire_one();
        else
        begin
            ph = PH_PAYLOAD;
            skip_left = n;
        end
    endfunction

    function automatic void begin_header(input logic [2:0] nbytes, input logic [1:0] kind);
        ph = PH_HEADER;
        hdr_left = nbytes;
        hdr_kind = kind;
        hdr_acc = '0;
    endfunction

    // The container itself is retired as it opens; returns 0 on overflow.
    function automatic bit open_container(input logic [63:0] children);
        logic [63:0] base;
        base = (owed != 0) ? 64'(owed) - 64'd1 : 64'd0;
        if (children > OWED_MAX - base)
            return 1'b0;
        owed = OWED_WIDTH'(base + children);
        ph = PH_TAG;
        return 1'b1;
    endfunction

    function automatic void parse_byte(input logic [7:0] b, input logic last,
                                       output logic [2:0] st, output logic [31:0] len);
        st = ST_BUSY;
        if (seen != '1)
            seen = seen + 32'd1;
        if (ph == PH_HEADER)
        begin
            hdr_acc = {hdr_acc[23:0], b};
            if (hdr_left != 0)
                hdr_left = hdr_left - 3'd1;
            if (hdr_left == 0)
            begin
                case (hdr_kind)
                    KIND_BYTES: begin_payload({1'b0, hdr_acc});
                    KIND_EXT:   begin_payload({1'b0, hdr_acc} + 33'd1);
                    KIND_ARRAY:
                        if (!open_container({32'd0, hdr_acc}))
                            st = ST_OVERFLOW;
                    default:
                        if (!open_container({31'd0, hdr_acc, 1'b0}))
                            st = ST_OVERFLOW;
                endcase
            end
        end
        else if (ph == PH_PAYLOAD)
        begin
            if (skip_left != 0)
                skip_left = skip_left - 33'd1;
            if (skip_left == 0)
                retire_one();
        end
        else if (b <= POSFIX_MAX || b >= NEGFIX || b == TAG_NIL || b == TAG_FALSE
                 || b == TAG_TRUE)
            retire_one();
        else if (b[7:5] == FIXSTR[7:5])
            begin_payload({28'd0, b[4:0]});
        else if (b[7:4] == FIXARRAY[7:4])
        begin
            if (!open_container({60'd0, b[3:0]}))
                st = ST_OVERFLOW;
        end
        else if (b[7:4] == FIXMAP[7:4])
        begin
            if (!open_container({59'd0, b[3:0], 1'b0}))
                st = ST_OVERFLOW;
        end
        else
        begin
            case (b)
                TAG_BIN8, TAG_STR8:           begin_header(3'd1, KIND_BYTES);
                TAG_BIN16, TAG_STR16:         begin_header(3'd2, KIND_BYTES);
                TAG_BIN32, TAG_STR32:         begin_header(3'd4, KIND_BYTES);
                TAG_EXT8:                     begin_header(3'd1, KIND_EXT);
                TAG_EXT16:                    begin_header(3'd2, KIND_EXT);
                TAG_EXT32:                    begin_header(3'd4, KIND_EXT);
                TAG_ARRAY16:                  begin_header(3'd2, KIND_ARRAY);
                TAG_ARRAY32:                  begin_header(3'd4, KIND_ARRAY);
                TAG_MAP16:                    begin_header(3'd2, KIND_MAP);
                TAG_MAP32:                    begin_header(3'd4, KIND_MAP);
                TAG_UINT8, TAG_INT8:          begin_payload(33'd1);
                TAG_UINT16, TAG_INT16, TAG_FIXEXT1: begin_payload(33'd2);
                TAG_FIXEXT2:                  begin_payload(33'd3);
                TAG_FLOAT32, TAG_UINT32, TAG_INT32: begin_payload(33'd4);
                TAG_FIXEXT4:                  begin_payload(33'd5);
                TAG_FLOAT64, TAG_UINT64, TAG_INT64: begin_payload(33'd8);
                TAG_FIXEXT8:                  begin_payload(33'd9);
                TAG_FIXEXT16:                 begin_payload(33'd17);
                default:                      st = ST_BADTAG;
            endcase
        end
        // Errors win over the end mark.
        if (st == ST_BUSY)
        begin
            if (ph == PH_TAG && owed == 0)
                st = ST_DONE;
            else if (last)
                st = ST_TRUNC;
        end
        len = seen;
        if (st != ST_BUSY)
            reset_parser();
    endfunction

    function automatic void add_byte(ref logic [7:0] s[$], input logic [7:0] b);
        s = {s, b};
    endfunction

    function automatic void append_be(ref logic [7:0] s[$], input logic [31:0] v,
                                      input int nbytes);
        for (int k = nbytes - 1; k >= 0; k--)
            add_byte(s, v[8*k +: 8]);
    endfunction

    function automatic void append_random(ref logic [7:0] s[$], input int unsigned n);
        repeat (n)
            add_byte(s, 8'($urandom_range(0, 255)));
    endfunction

    // Appends one well-formed value with random content; nesting stops at depth 3.
    function automatic void build_value(input int unsigned depth, ref logic [7:0] s[$]);
        int unsigned pick;
        int unsigned n;
        int unsigned k;
        int          w;
        logic [7:0]  tag;
        pick = $urandom_range(0, 15);
        if (depth >= 3 && pick >= 10)
            pick = 0;
        case (pick)
            0: add_byte(s, 8'($urandom_range(0, 127)));
            1: add_byte(s, NEGFIX | 8'($urandom_range(0, 31)));
            2:
            begin
                k = $urandom_range(0, 2);
                add_byte(s, k == 0 ? TAG_NIL : (k == 1 ? TAG_FALSE : TAG_TRUE));
            end
            3:
            begin
                n = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 31) : $urandom_range(0, 4);
                add_byte(s, FIXSTR | 8'(n));
                append_random(s, n);
            end
            4, 5, 6:
            begin
                n = $urandom_range(0, 12);
                k = $urandom_range(0, 1);
                if (pick == 4)
                begin
                    tag = k ? TAG_BIN8 : TAG_STR8;
                    w = 1;
                end
                else if (pick == 5)
                begin
                    tag = k ? TAG_BIN16 : TAG_STR16;
                    w = 2;
                end
                else
                begin
                    tag = k ? TAG_BIN32 : TAG_STR32;
                    w = 4;
                end
                add_byte(s, tag);
                append_be(s, n, w);
                append_random(s, n);
            end
            7:
            begin
                n = $urandom_range(0, 10);
                k = $urandom_range(0, 2);
                add_byte(s, k == 0 ? TAG_EXT8 : (k == 1 ? TAG_EXT16 : TAG_EXT32));
                append_be(s, n, 1 << k);
                // The type byte comes ahead of the data.
                append_random(s, n + 1);
            end
            8:
            begin
                k = $urandom_range(0, 4);
                add_byte(s, TAG_FIXEXT1 + 8'(k));
                append_random(s, (1 << k) + 1);
            end
            9:
            begin
                case ($urandom_range(0, 9))
                    0: begin tag = TAG_UINT8;   n = 1; end
                    1: begin tag = TAG_INT8;    n = 1; end
                    2: begin tag = TAG_UINT16;  n = 2; end
                    3: begin tag = TAG_INT16;   n = 2; end
                    4: begin tag = TAG_UINT32;  n = 4; end
                    5: begin tag = TAG_INT32;   n = 4; end
                    6: begin tag = TAG_FLOAT32; n = 4; end
                    7: begin tag = TAG_UINT64;  n = 8; end
                    8: begin tag = TAG_INT64;   n = 8; end
                    default: begin tag = TAG_FLOAT64; n = 8; end
                endcase
                add_byte(s, tag);
                append_random(s, n);
            end
            10:
            begin
                n = (depth == 0 && $urandom_range(0, 7) == 0) ? $urandom_range(0, 15)
                                                               : $urandom_range(0, 4);
                add_byte(s, FIXARRAY | 8'(n));
                repeat (n)
                    build_value(depth + 1, s);
            end
            11:
            begin
                n = (depth == 0 && $urandom_range(0, 7) == 0) ? $urandom_range(0, 15)
                                                               : $urandom_range(0, 3);
                add_byte(s, FIXMAP | 8'(n));
                repeat (2 * n)
                    build_value(depth + 1, s);
            end
            12, 13:
            begin
                n = $urandom_range(0, 4);
                add_byte(s, pick == 12 ? TAG_ARRAY16 : TAG_ARRAY32);
                append_be(s, n, pick == 12 ? 2 : 4);
                repeat (n)
                    build_value(depth + 1, s);
            end
            default:
            begin
                n = $urandom_range(0, 3);
                add_byte(s, pick == 14 ? TAG_MAP16 : TAG_MAP32);
                append_be(s, n, pick == 14 ? 2 : 4);
                repeat (2 * n)
                    build_value(depth + 1, s);
            end
        endcase
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("%0t mismatch on %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
        mismatches++;
    endtask

    // Offers one byte and waits until it is accepted; the prediction is made on acceptance.
    task automatic push_byte(input logic [7:0] b, input logic last);
        skip_result_t r;
        logic [2:0]   st;
        logic [31:0]  len;
        if (idle_en && $urandom_range(0, 4) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 11))
                @(posedge clk);
        end
        in_valid <= 1'b1;
        data_byte <= b;
        buffer_end <= last;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        parse_byte(b, last, st, len);
        r.status = st;
        r.length = len;
        status_queue = {status_queue, r};
        bytes_sent++;
    endtask

    task automatic push_stream(ref logic [7:0] s[$], input logic mark_end);
        for (int i = 0; i < s.size(); i++)
            push_byte(s[i], mark_end && (i == s.size() - 1));
    endtask

    task automatic test_scalar_tags();
        push_byte(8'h00, 1'b0);
        push_byte(POSFIX_MAX, 1'b0);
        push_byte(NEGFIX, 1'b0);
        push_byte(8'hff, 1'b0);
        push_byte(TAG_NIL, 1'b0);
        push_byte(TAG_FALSE, 1'b0);
        // A value that completes on the marked byte is complete, not truncated.
        push_byte(TAG_TRUE, 1'b1);
    endtask

    task automatic test_zero_lengths();
        push_byte(FIXSTR, 1'b0);
        push_byte(FIXARRAY, 1'b0);
        push_byte(FIXMAP, 1'b0);
        push_byte(TAG_BIN8, 1'b0);
        push_byte(8'h00, 1'b0);
        push_byte(TAG_MAP32, 1'b0);
        repeat (4)
            push_byte(8'h00, 1'b0);
    endtask

    task automatic test_bad_tag();
        push_byte(TAG_NEVER, 1'b0);
        push_byte(FIXARRAY | 8'd1, 1'b0);
        push_byte(TAG_NEVER, 1'b1);
    endtask

    task automatic test_truncation();
        push_byte(FIXARRAY | 8'd2, 1'b0);
        push_byte(8'h01, 1'b1);
        push_byte(8'h05, 1'b1);
    endtask

    task automatic test_count_overflow();
        // Each map32 of 0xffffffff pairs adds 2^33 - 3 to the owed count.
        repeat (128)
        begin
            push_byte(TAG_MAP32, 1'b0);
            repeat (4)
                push_byte(8'hff, 1'b0);
        end
        // 383 more children bring the count exactly to its maximum.
        push_byte(TAG_ARRAY32, 1'b0);
        push_byte(8'h00, 1'b0);
        push_byte(8'h00, 1'b0);
        push_byte(8'h01, 1'b0);
        push_byte(8'h7f, 1'b0);
        push_byte(FIXARRAY | 8'd1, 1'b0);
        push_byte(FIXARRAY | 8'd2, 1'b1);
    endtask

    task automatic test_output_backpressure();
        logic [7:0] s[$];
        idle_en = 1'b0;
        fork
            begin
                hold_req <= 1'b1;
                repeat (300)
                    @(posedge clk);
                hold_req <= 1'b0;
            end
            begin
                repeat (20)
                begin
                    s.delete();
                    build_value(1, s);
                    push_stream(s, 1'b0);
                end
            end
        join
        idle_en = 1'b1;
    endtask

    task automatic test_random_streams();
        logic [7:0]  s[$];
        int unsigned start;
        int unsigned r;
        int unsigned n;
        start = bytes_sent;
        while (bytes_sent - start < 500)
        begin
            if (bytes_sent - start >= 420)
                idle_en = 1'b0;
            s.delete();
            r = $urandom_range(0, 99);
            if (r < 65)
            begin
                build_value(0, s);
                push_stream(s, $urandom_range(0, 3) == 0);
            end
            else if (r < 80)
            begin
                build_value(0, s);
                if (s.size() > 1)
                begin
                    n = $urandom_range(1, s.size() - 1);
                    while (s.size() > n)
                        void'(s.pop_back());
                end
                push_stream(s, 1'b1);
            end
            else if (r < 88)
            begin
                append_random(s, $urandom_range(1, 8));
                push_stream(s, 1'b1);
            end
            else if (r < 94)
            begin
                build_value(0, s);
                s.insert($urandom_range(0, s.size() - 1), TAG_NEVER);
                push_stream(s, 1'b0);
            end
            else
            begin
                // Two- and four-byte length headers with random length bytes, then random bytes up to the end mark.
                case ($urandom_range(0, 6))
                    0: add_byte(s, TAG_BIN32);
                    1: add_byte(s, TAG_STR32);
                    2: add_byte(s, TAG_EXT32);
                    3: add_byte(s, TAG_ARRAY32);
                    4: add_byte(s, TAG_MAP32);
                    5: add_byte(s, TAG_EXT16);
                    default: add_byte(s, TAG_MAP16);
                endcase
                append_random(s, 4);
                append_random(s, $urandom_range(1, 6));
                push_stream(s, 1'b1);
            end
        end
    endtask

    always @(posedge clk)
    begin : result_check
        skip_result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (status_queue.size() == 0)
                report_mismatch("unexpected transaction, status", {29'd0, status}, '0);
            else
            begin
                want = status_queue.pop_front();
                if (status !== want.status)
                    report_mismatch("status", {29'd0, status}, {29'd0, want.status});
                if (value_length !== want.length)
                    report_mismatch("value_length", value_length, want.length);
            end
        end
        if (hold_req)
            out_stall <= 1'b1;
        else if (stall_left != 0)
        begin
            out_stall <= 1'b1;
            stall_left <= stall_left - 1;
        end
        else if (idle_en && $urandom_range(0, 5) == 0)
        begin
            out_stall <= 1'b1;
            stall_left <= $urandom_range(0, 10);
        end
        else
            out_stall <= 1'b0;
    end

    initial
    begin
        reset_parser();
        repeat (5)
            @(posedge clk);
        rst_n <= 1'b1;
        test_scalar_tags();
        test_zero_lengths();
        test_bad_tag();
        test_truncation();
        test_count_overflow();
        test_output_backpressure();
        test_random_streams();
        in_valid <= 1'b0;
        while (status_queue.size() != 0)
            @(posedge clk);
        repeat (10)
            @(posedge clk);
        if (mismatches == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    initial
    begin
        #5_000_000;
        $display("CHECK FAILED");
        $finish;
    end

endmodule

// File: msgpack_value_skipper_top.f
sv/mvs_pkg.sv
sv/mvs_front.sv
sv/mvs_queue.sv
sv/mvs_back.sv
sv/msgpack_value_skipper_top.sv
tb/msgpack_value_skipper_top_tb.sv
